@@ rtl/rcs_pkg.sv @@
// rcs_pkg: shared types, codes and defaults for the read correction scorer.
// No dependencies; imported by every rcs module and the top level.
package rcs_pkg;

    localparam int COUNTER_WIDTH_DEF    = 32;
    localparam int READ_COUNT_WIDTH_DEF = 16;
    localparam int OUT_W                = 32;
    localparam int BASE_W               = 8;

    // kind field of an input transaction
    typedef enum logic [1:0] {
        KIND_PAIR     = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_PARTIAL  = 2'd2,
        KIND_UNFILLED = 2'd3
    } kind_t;

    // per-pair score
    typedef enum logic [1:0] {
        OUTC_NONE = 2'd0,
        OUTC_TP   = 2'd1,
        OUTC_FP   = 2'd2,
        OUTC_FN   = 2'd3
    } outcome_t;

    typedef struct packed {
        kind_t               kind;
        logic [BASE_W-1:0]   orig_first;
        logic [BASE_W-1:0]   orig_second;
        logic [BASE_W-1:0]   corr_first;
        logic [BASE_W-1:0]   corr_second;
        logic [BASE_W-1:0]   ref_first;
        logic [BASE_W-1:0]   ref_second;
        logic                last_pair;
    } item_t;

    // control handed from the compare stage to the counter bank
    typedef struct packed {
        logic     update;
        kind_t    kind;
        logic     last_pair;
        outcome_t outcome;
    } tally_ctl_t;

endpackage

@@ rtl/read_correction_scorer.sv @@
// read_correction_scorer: top level, input register, pair compare, counter bank.
// Depends on rcs_pkg, rcs_pair_cmp and rcs_tally.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in      | into      | in_valid / in_stall  | kind, orig_*, corr_*, ref_*, last_pair
//  out     | out of    | out_valid / out_stall| pair_outcome, eight running counters
//
// One result transaction per input transaction. An accepted item sits in the
// input register; once the result slot is free or emptying, compare and counter
// update load the counters and outcome register, which drive the result.
// Throughput is one transaction per cycle while the output is not stalled.
// Reset (rst_n low, async) clears all counters and both valid flags. A stalled
// result holds; the input stalls only while its register is full behind it.
module read_correction_scorer
    import rcs_pkg::*;
#(
    parameter int COUNTER_WIDTH    = COUNTER_WIDTH_DEF,
    parameter int READ_COUNT_WIDTH = READ_COUNT_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  logic [BASE_W-1:0] orig_first,
    input  logic [BASE_W-1:0] orig_second,
    input  logic [BASE_W-1:0] corr_first,
    input  logic [BASE_W-1:0] corr_second,
    input  logic [BASE_W-1:0] ref_first,
    input  logic [BASE_W-1:0] ref_second,
    input  logic              last_pair,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        pair_outcome,
    output logic [OUT_W-1:0]  true_pos_count,
    output logic [OUT_W-1:0]  false_pos_count,
    output logic [OUT_W-1:0]  false_neg_count,
    output logic [OUT_W-1:0]  reads_processed,
    output logic [OUT_W-1:0]  reads_seen,
    output logic [OUT_W-1:0]  good_corrections,
    output logic [OUT_W-1:0]  clean_reads,
    output logic [OUT_W-1:0]  bad_corrections
);

    item_t      item_reg;
    logic       item_vld_reg;
    logic       out_vld_reg;
    outcome_t   outcome_reg;
    outcome_t   outcome;
    tally_ctl_t ctl;
    logic       accept;
    logic       advance;

    logic [COUNTER_WIDTH-1:0] tp_cnt, fp_cnt, fn_cnt, proc_cnt;
    logic [COUNTER_WIDTH-1:0] seen_cnt, good_cnt, clean_cnt, bad_cnt;

    // item moves to the result side when the result slot is free or emptying
    assign advance  = item_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = item_vld_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                item_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.kind        <= kind_t'(kind);
            item_reg.orig_first  <= orig_first;
            item_reg.orig_second <= orig_second;
            item_reg.corr_first  <= corr_first;
            item_reg.corr_second <= corr_second;
            item_reg.ref_first   <= ref_first;
            item_reg.ref_second  <= ref_second;
            item_reg.last_pair   <= last_pair;
        end
        if (advance)
        begin
            outcome_reg <= outcome;
        end
    end

    rcs_pair_cmp u_pair_cmp
    (
        .item    (item_reg),
        .outcome (outcome)
    );

    assign ctl.update    = advance;
    assign ctl.kind      = item_reg.kind;
    assign ctl.last_pair = item_reg.last_pair;
    assign ctl.outcome   = outcome;

    // counters only move on advance, so they double as the result register
    rcs_tally #(
        .COUNTER_WIDTH    (COUNTER_WIDTH),
        .READ_COUNT_WIDTH (READ_COUNT_WIDTH)
    ) u_tally (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .true_pos  (tp_cnt),
        .false_pos (fp_cnt),
        .false_neg (fn_cnt),
        .processed (proc_cnt),
        .seen      (seen_cnt),
        .good_corr (good_cnt),
        .clean     (clean_cnt),
        .bad_corr  (bad_cnt)
    );

    assign out_valid        = out_vld_reg;
    assign pair_outcome     = outcome_reg;
    // reported in the low 32 bits, zero-extended when narrower
    assign true_pos_count   = OUT_W'(tp_cnt);
    assign false_pos_count  = OUT_W'(fp_cnt);
    assign false_neg_count  = OUT_W'(fn_cnt);
    assign reads_processed  = OUT_W'(proc_cnt);
    assign reads_seen       = OUT_W'(seen_cnt);
    assign good_corrections = OUT_W'(good_cnt);
    assign clean_reads      = OUT_W'(clean_cnt);
    assign bad_corrections  = OUT_W'(bad_cnt);

    // an empty result slot never backs up the input side
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> !in_stall)
        else $error("input stalled while result slot empty");

    // a blocked item stays put in the input register
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (item_vld_reg && out_vld_reg && out_stall) |=> (item_vld_reg && $stable(item_reg)))
        else $error("blocked item lost or changed");

    // every advance produces a visible result next cycle
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("advance without result");

endmodule

@@ rtl/rcs_pair_cmp.sv @@
// rcs_pair_cmp: scores one aligned base pair against the reference.
// Depends on rcs_pkg.
module rcs_pair_cmp
    import rcs_pkg::*;
(
    input  item_t    item,
    output outcome_t outcome
);

    logic orig_err;
    logic corr_ok;
    logic corr_changed;

    assign orig_err     = (item.orig_first != item.ref_first)
                       || (item.orig_second != item.ref_second);
    assign corr_ok      = (item.corr_first == item.ref_first)
                       && (item.corr_second == item.ref_second);
    assign corr_changed = (item.corr_first != item.orig_first)
                       || (item.corr_second != item.orig_second);

    always_comb
    begin
        outcome = OUTC_NONE;
        if (item.kind == KIND_PAIR)
        begin
            if (orig_err)
            begin
                outcome = corr_ok ? OUTC_TP : OUTC_FN;
            end
            else if (corr_changed)
            begin
                outcome = OUTC_FP;
            end
        end
    end

endmodule

@@ rtl/rcs_tally.sv @@
// rcs_tally: per-read and running saturating counters, read classification.
// Depends on rcs_pkg.
module rcs_tally
    import rcs_pkg::*;
#(
    parameter int COUNTER_WIDTH    = COUNTER_WIDTH_DEF,
    parameter int READ_COUNT_WIDTH = READ_COUNT_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  tally_ctl_t               ctl,
    output logic [COUNTER_WIDTH-1:0] true_pos,
    output logic [COUNTER_WIDTH-1:0] false_pos,
    output logic [COUNTER_WIDTH-1:0] false_neg,
    output logic [COUNTER_WIDTH-1:0] processed,
    output logic [COUNTER_WIDTH-1:0] seen,
    output logic [COUNTER_WIDTH-1:0] good_corr,
    output logic [COUNTER_WIDTH-1:0] clean,
    output logic [COUNTER_WIDTH-1:0] bad_corr
);

    typedef logic [COUNTER_WIDTH-1:0]    cnt_t;
    typedef logic [READ_COUNT_WIDTH-1:0] rd_t;

    function automatic cnt_t sat_cnt(input cnt_t c, input logic en);
        sat_cnt = (en && !(&c)) ? c + cnt_t'(1) : c;
    endfunction

    function automatic rd_t sat_rd(input rd_t c, input logic en);
        sat_rd = (en && !(&c)) ? c + rd_t'(1) : c;
    endfunction

    cnt_t tp_reg, fp_reg, fn_reg, proc_reg, seen_reg, good_reg, clean_reg, bad_reg;
    cnt_t tp_next, fp_next, fn_next, proc_next, seen_next, good_next, clean_next, bad_next;
    rd_t  rtp_reg, rfp_reg, rfn_reg;
    rd_t  rtp_next, rfp_next, rfn_next;

    // read counts after this pair, before any read-end clear
    rd_t  rtp_pair, rfp_pair, rfn_pair;
    rd_t  etp, efp, efn;
    logic is_pair, is_tp, is_fp, is_fn;
    logic finish, no_err;

    assign is_pair = (ctl.kind == KIND_PAIR);
    assign is_tp   = (ctl.outcome == OUTC_TP);
    assign is_fp   = (ctl.outcome == OUTC_FP);
    assign is_fn   = (ctl.outcome == OUTC_FN);

    assign rtp_pair = sat_rd(rtp_reg, is_tp);
    assign rfp_pair = sat_rd(rfp_reg, is_fp);
    assign rfn_pair = sat_rd(rfn_reg, is_fn);

    // empty read classifies with zero counts
    assign etp = is_pair ? rtp_pair : '0;
    assign efp = is_pair ? rfp_pair : '0;
    assign efn = is_pair ? rfn_pair : '0;

    assign finish = (is_pair && ctl.last_pair) || (ctl.kind == KIND_EMPTY);
    assign no_err = (efp == '0) && (efn == '0);

    always_comb
    begin
        tp_next    = sat_cnt(tp_reg, is_tp);
        fp_next    = sat_cnt(fp_reg, is_fp);
        fn_next    = sat_cnt(fn_reg, is_fn);
        proc_next  = sat_cnt(proc_reg, finish);
        seen_next  = sat_cnt(seen_reg, finish || (ctl.kind == KIND_PARTIAL));
        good_next  = sat_cnt(good_reg, finish && no_err && (etp != '0));
        clean_next = sat_cnt(clean_reg, finish && no_err && (etp == '0));
        bad_next   = sat_cnt(bad_reg, finish && !no_err && (efp > efn));
        if (is_pair && !ctl.last_pair)
        begin
            rtp_next = rtp_pair;
            rfp_next = rfp_pair;
            rfn_next = rfn_pair;
        end
        else
        begin
            rtp_next = '0;
            rfp_next = '0;
            rfn_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tp_reg    <= '0;
            fp_reg    <= '0;
            fn_reg    <= '0;
            proc_reg  <= '0;
            seen_reg  <= '0;
            good_reg  <= '0;
            clean_reg <= '0;
            bad_reg   <= '0;
            rtp_reg   <= '0;
            rfp_reg   <= '0;
            rfn_reg   <= '0;
        end
        else if (ctl.update)
        begin
            tp_reg    <= tp_next;
            fp_reg    <= fp_next;
            fn_reg    <= fn_next;
            proc_reg  <= proc_next;
            seen_reg  <= seen_next;
            good_reg  <= good_next;
            clean_reg <= clean_next;
            bad_reg   <= bad_next;
            rtp_reg   <= rtp_next;
            rfp_reg   <= rfp_next;
            rfn_reg   <= rfn_next;
        end
    end

    assign true_pos  = tp_reg;
    assign false_pos = fp_reg;
    assign false_neg = fn_reg;
    assign processed = proc_reg;
    assign seen      = seen_reg;
    assign good_corr = good_reg;
    assign clean     = clean_reg;
    assign bad_corr  = bad_reg;

endmodule

@@ tb/tb_read_correction_scorer.sv @@
`timescale 1ns / 1ps
// tb_read_correction_scorer: self-checking testbench for read_correction_scorer.
// Depends on rcs_pkg and the read_correction_scorer RTL; nothing else.
// Directed reads first, then random transactions up to ~450 in all, with bursty input and stalled output.
module tb_read_correction_scorer;
    import rcs_pkg::*;

    localparam int RW             = READ_COUNT_WIDTH_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TARGET_ITEMS   = 450;
    localparam int HOLD_CYCLES    = 60;
    localparam int MAX_PRINTED    = 40;
    localparam logic [OUT_W-1:0] CNT_TOP = '1;
    localparam logic [OUT_W-1:0] RD_TOP  = {{(OUT_W-RW){1'b0}}, {RW{1'b1}}};

    // one result transaction: outcome of the pair plus all running counters
    typedef struct packed {
        outcome_t           outcome;
        logic [OUT_W-1:0]   tp;
        logic [OUT_W-1:0]   fp;
        logic [OUT_W-1:0]   fn;
        logic [OUT_W-1:0]   processed;
        logic [OUT_W-1:0]   seen;
        logic [OUT_W-1:0]   good;
        logic [OUT_W-1:0]   clean;
        logic [OUT_W-1:0]   bad;
    } score_t;

    // a pending input transaction; drain_first holds it back until all results are in
    typedef struct {
        item_t it;
        bit    drain_first;
    } send_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        kind = KIND_PAIR;
    logic [BASE_W-1:0] orig_first = '0;
    logic [BASE_W-1:0] orig_second = '0;
    logic [BASE_W-1:0] corr_first = '0;
    logic [BASE_W-1:0] corr_second = '0;
    logic [BASE_W-1:0] ref_first = '0;
    logic [BASE_W-1:0] ref_second = '0;
    logic              last_pair = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [1:0]        pair_outcome;
    logic [OUT_W-1:0]  true_pos_count;
    logic [OUT_W-1:0]  false_pos_count;
    logic [OUT_W-1:0]  false_neg_count;
    logic [OUT_W-1:0]  reads_processed;
    logic [OUT_W-1:0]  reads_seen;
    logic [OUT_W-1:0]  good_corrections;
    logic [OUT_W-1:0]  clean_reads;
    logic [OUT_W-1:0]  bad_corrections;

    read_correction_scorer dut (.*);

    // scorer state mirror: totals and counts of the read in progress
    logic [OUT_W-1:0] tot_tp = '0, tot_fp = '0, tot_fn = '0;
    logic [OUT_W-1:0] tot_processed = '0, tot_seen = '0;
    logic [OUT_W-1:0] tot_good = '0, tot_clean = '0, tot_bad = '0;
    logic [RW-1:0]    rd_tp = '0, rd_fp = '0, rd_fn = '0;

    send_t  reads_to_send[$];   // stimulus not yet on the wire
    score_t scores_due[$];      // predicted results, oldest first
    item_t  on_wire;            // transaction currently driven
    int     planned = 0;
    int     err_count = 0;
    int     burst_left = 0;
    int     gap_left = 0;
    int     rx_cycle = 0;
    int     hold_left = 0;
    int     stall_mode = 0;
    int     mode_left = 0;
    int     idle_cycles = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [OUT_W-1:0] sat_inc(input logic [OUT_W-1:0] v,
                                                 input logic [OUT_W-1:0] top);
        return (v < top) ? v + 1'b1 : v;
    endfunction

    function automatic void clear_read();
        rd_tp = '0;
        rd_fp = '0;
        rd_fn = '0;
    endfunction

    // End of a complete read: classify on the (saturated) per-read counts.
    function automatic void close_read();
        tot_processed = sat_inc(tot_processed, CNT_TOP);
        tot_seen      = sat_inc(tot_seen, CNT_TOP);
        if (rd_fp == '0 && rd_fn == '0)
        begin
            if (rd_tp != '0)
                tot_good = sat_inc(tot_good, CNT_TOP);
            else
                tot_clean = sat_inc(tot_clean, CNT_TOP);
        end
        else if (rd_fp > rd_fn)
        begin
            tot_bad = sat_inc(tot_bad, CNT_TOP);
        end
        clear_read();
    endfunction

    // Advances the mirror by one input transaction and returns the result it causes.
    function automatic score_t score_item(input item_t it);
        score_t   s;
        outcome_t oc;
        oc = OUTC_NONE;
        case (it.kind)
            KIND_PAIR:
            begin
                if (it.orig_first != it.ref_first || it.orig_second != it.ref_second)
                begin
                    if (it.corr_first == it.ref_first && it.corr_second == it.ref_second)
                    begin
                        oc     = OUTC_TP;
                        rd_tp  = RW'(sat_inc(OUT_W'(rd_tp), RD_TOP));
                        tot_tp = sat_inc(tot_tp, CNT_TOP);
                    end
                    else
                    begin
                        oc     = OUTC_FN;
                        rd_fn  = RW'(sat_inc(OUT_W'(rd_fn), RD_TOP));
                        tot_fn = sat_inc(tot_fn, CNT_TOP);
                    end
                end
                else if (it.corr_first != it.orig_first || it.corr_second != it.orig_second)
                begin
                    oc     = OUTC_FP;
                    rd_fp  = RW'(sat_inc(OUT_W'(rd_fp), RD_TOP));
                    tot_fp = sat_inc(tot_fp, CNT_TOP);
                end
                if (it.last_pair)
                    close_read();
            end
            KIND_EMPTY:
            begin
                clear_read();
                close_read();
            end
            KIND_PARTIAL:
            begin
                clear_read();
                tot_seen = sat_inc(tot_seen, CNT_TOP);
            end
            default:
                clear_read();
        endcase
        s.outcome   = oc;
        s.tp        = tot_tp;
        s.fp        = tot_fp;
        s.fn        = tot_fn;
        s.processed = tot_processed;
        s.seen      = tot_seen;
        s.good      = tot_good;
        s.clean     = tot_clean;
        s.bad       = tot_bad;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic item_t mk(input kind_t k,
                                 input logic [7:0] of, input logic [7:0] os,
                                 input logic [7:0] cf, input logic [7:0] cs,
                                 input logic [7:0] rf, input logic [7:0] rs,
                                 input logic lp);
        item_t it;
        it.kind        = k;
        it.orig_first  = of;
        it.orig_second = os;
        it.corr_first  = cf;
        it.corr_second = cs;
        it.ref_first   = rf;
        it.ref_second  = rs;
        it.last_pair   = lp;
        return it;
    endfunction

    // mostly nucleotide letters, sometimes any byte so every bit toggles
    function automatic logic [7:0] pick_base();
        logic [7:0] letters [5];
        letters = '{"A", "C", "G", "T", "N"};
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        return letters[$urandom_range(0, 4)];
    endfunction

    function automatic logic [7:0] other_base(input logic [7:0] b);
        logic [7:0] n;
        do
            n = pick_base();
        while (n == b);
        return n;
    endfunction

    // builds a pair transaction that should score as the given outcome
    function automatic item_t make_pair(input outcome_t want, input logic lp);
        item_t it;
        int    which;
        it.kind        = KIND_PAIR;
        it.last_pair   = lp;
        it.ref_first   = pick_base();
        it.ref_second  = pick_base();
        it.orig_first  = it.ref_first;
        it.orig_second = it.ref_second;
        which = $urandom_range(0, 2);
        if (want == OUTC_TP || want == OUTC_FN)
        begin
            if (which != 1) it.orig_first  = other_base(it.ref_first);
            if (which != 0) it.orig_second = other_base(it.ref_second);
        end
        it.corr_first  = it.orig_first;
        it.corr_second = it.orig_second;
        which = $urandom_range(0, 2);
        case (want)
            OUTC_TP:
            begin
                it.corr_first  = it.ref_first;
                it.corr_second = it.ref_second;
            end
            OUTC_FP:
            begin
                if (which != 1) it.corr_first  = other_base(it.orig_first);
                if (which != 0) it.corr_second = other_base(it.orig_second);
            end
            OUTC_FN:
            begin
                // either left uncorrected, or corrected to something still wrong
                if ($urandom_range(0, 1) == 0)
                begin
                    it.corr_first  = it.ref_first;
                    it.corr_second = it.ref_second;
                    if (which != 1) it.corr_first  = other_base(it.ref_first);
                    if (which != 0) it.corr_second = other_base(it.ref_second);
                end
            end
            default: ;
        endcase
        return it;
    endfunction

    // per-read flavor steers the classification: clean, good, bad or mixed
    function automatic outcome_t pick_outcome(input int flavor);
        int r;
        r = $urandom_range(0, 9);
        case (flavor)
            0:       return OUTC_NONE;
            1:       return (r < 5) ? OUTC_TP : OUTC_NONE;
            2:       return (r < 6) ? OUTC_FP : ((r < 8) ? OUTC_FN : OUTC_NONE);
            default: return outcome_t'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic item_t noise_item(input kind_t k);
        return mk(k, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 1'($urandom));
    endfunction

    task automatic post(input item_t it, input bit drain_first);
        send_t t;
        t.it          = it;
        t.drain_first = drain_first;
        reads_to_send.push_back(t);
        planned++;
    endtask

    task automatic report(input string what, input logic [OUT_W-1:0] got,
                          input logic [OUT_W-1:0] want);
        if (err_count < MAX_PRINTED)
            $display("ERROR @%0t: %s got %0h expected %0h", $time, what, got, want);
        err_count++;
    endtask

    task automatic check_field(input string what, input logic [OUT_W-1:0] got,
                               input logic [OUT_W-1:0] want);
        if (got !== want)
            report(what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of transactions with random gaps. The payload is held
    // while stalled; a transaction marked drain_first waits until every
    // predicted result has been collected.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            kind        <= KIND_PAIR;
            orig_first  <= '0;
            orig_second <= '0;
            corr_first  <= '0;
            corr_second <= '0;
            ref_first   <= '0;
            ref_second  <= '0;
            last_pair   <= 1'b0;
            burst_left  = 0;
            gap_left    = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                scores_due.push_back(score_item(on_wire));

            if (in_valid && in_stall)
            begin
                // stalled: hold valid and payload
            end
            else if (gap_left != 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (reads_to_send.size() != 0 &&
                     !(reads_to_send[0].drain_first && scores_due.size() != 0))
            begin
                on_wire = reads_to_send[0].it;
                void'(reads_to_send.pop_front());
                kind        <= on_wire.kind;
                orig_first  <= on_wire.orig_first;
                orig_second <= on_wire.orig_second;
                corr_first  <= on_wire.corr_first;
                corr_second <= on_wire.corr_second;
                ref_first   <= on_wire.ref_first;
                ref_second  <= on_wire.ref_second;
                last_pair   <= on_wire.last_pair;
                in_valid    <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern: modes of random length (none, light, half,
    // heavy), plus two long hold-offs that back the scorer up into its input.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            rx_cycle   = 0;
            hold_left  = 0;
            stall_mode = 0;
            mode_left  = 0;
        end
        else
        begin
            rx_cycle++;
            if (rx_cycle == 150 || rx_cycle == 700)
                hold_left = HOLD_CYCLES;
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(10, 60);
            end
            else
            begin
                mode_left--;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= 1'($urandom_range(0, 1));
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted result transaction against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        score_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (scores_due.size() == 0)
            begin
                report("result with nothing outstanding, reads_seen", reads_seen, '0);
            end
            else
            begin
                want = scores_due.pop_front();
                check_field("pair_outcome", OUT_W'(pair_outcome), OUT_W'(want.outcome));
                check_field("true_pos_count", true_pos_count, want.tp);
                check_field("false_pos_count", false_pos_count, want.fp);
                check_field("false_neg_count", false_neg_count, want.fn);
                check_field("reads_processed", reads_processed, want.processed);
                check_field("reads_seen", reads_seen, want.seen);
                check_field("good_corrections", good_corrections, want.good);
                check_field("clean_reads", clean_reads, want.clean);
                check_field("bad_corrections", bad_corrections, want.bad);
            end
        end
    end

    // Watchdog: too long without a transaction on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("ERROR: no transaction for %0d cycles, %0d results outstanding",
                         idle_cycles, scores_due.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int len;
        int flavor;
        int sel;
        bit drain;

        // directed reads
        post(mk(KIND_PAIR, "A", "C", "A", "C", "A", "C", 1'b0), 1'b0);  // match, nothing
        post(mk(KIND_PAIR, "G", "C", "A", "C", "A", "C", 1'b0), 1'b0);  // fixed first base
        post(mk(KIND_PAIR, "A", "T", "A", "T", "A", "C", 1'b0), 1'b0);  // left uncorrected
        post(mk(KIND_PAIR, "A", "C", "A", "G", "A", "C", 1'b1), 1'b0);  // miscorrected; fp == fn
        post(mk(KIND_PAIR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1), 1'b0); // clean
        post(mk(KIND_PAIR, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1), 1'b0); // good
        post(mk(KIND_PAIR, "T", "T", "T", "A", "T", "T", 1'b0), 1'b0);  // fp
        post(mk(KIND_PAIR, "G", "G", "C", "C", "G", "G", 1'b0), 1'b0);  // fp
        post(mk(KIND_PAIR, "N", "G", "N", "G", "C", "G", 1'b1), 1'b0);  // fn; fp > fn -> bad
        post(mk(KIND_PAIR, "A", "A", "C", "A", "G", "A", 1'b1), 1'b0);  // fn only read
        post(mk(KIND_EMPTY, 8'hFF, 8'h00, 8'h5A, 8'hA5, 8'h0F, 8'hF0, 1'b1), 1'b1);
        post(mk(KIND_PAIR, "C", "A", "A", "A", "A", "A", 1'b0), 1'b0);  // tp, read unfinished
        post(mk(KIND_PARTIAL, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1), 1'b0);
        post(mk(KIND_PAIR, "A", "A", "A", "T", "A", "A", 1'b0), 1'b0);  // fp, read unfinished
        post(mk(KIND_UNFILLED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b0);
        post(mk(KIND_PAIR, "G", "T", "G", "T", "G", "T", 1'b1), 1'b0);  // clean after discard
        post(mk(KIND_PAIR, "C", "A", "A", "A", "A", "A", 1'b0), 1'b0);  // tp, then empty read
        post(mk(KIND_EMPTY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
        post(mk(KIND_PAIR, "T", "T", "A", "T", "A", "A", 1'b1), 1'b0);  // half fixed -> fn
        post(mk(KIND_PAIR, "T", "T", "A", "A", "A", "A", 1'b1), 1'b0);  // both fixed -> good

        // random part: mostly complete reads, some abandoned reads, some noise
        drain = 1'b1;
        while (planned < TARGET_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 80)
            begin
                len    = $urandom_range(1, 8);
                flavor = $urandom_range(0, 3);
                for (int i = 0; i < len; i++)
                    post(make_pair(pick_outcome(flavor), i == len - 1), drain && i == 0);
            end
            else if (sel < 90)
            begin
                len    = $urandom_range(1, 4);
                flavor = $urandom_range(0, 3);
                for (int i = 0; i < len; i++)
                    post(make_pair(pick_outcome(flavor), 1'b0), drain && i == 0);
                post(noise_item(kind_t'($urandom_range(1, 3))), 1'b0);
            end
            else
            begin
                post(noise_item(kind_t'($urandom_range(0, 3))), drain);
            end
            drain = ($urandom_range(0, 59) == 0);
        end

        repeat (5) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (reads_to_send.size() != 0 || in_valid || scores_due.size() != 0)
            @(negedge clk);
        // let any stray result transaction surface
        repeat (8) @(negedge clk);

        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
